>>> sv/tgi_pkg.sv
package tgi_pkg;

	localparam int AXIS_POINTS = 16;
	localparam int NUM_AXES = 3;
	localparam int IDX_W = 4;
	localparam int HALF_W = IDX_W - 1;
	localparam int BANK_DEPTH = AXIS_POINTS / 2;
	localparam int GRID_AW = NUM_AXES * HALF_W;
	localparam int GRID_BANK_DEPTH = BANK_DEPTH * BANK_DEPTH * BANK_DEPTH;
	localparam int NUM_BANKS = 8;

	localparam int VALUE_BITS = 32;
	localparam int SAT_BITS = (VALUE_BITS < 32) ? VALUE_BITS : 32;
	localparam int DATA_W = 32;
	localparam int FRAC_BITS = 16;
	localparam int FRAC_W = FRAC_BITS + 1;
	localparam int DIV_STAGES = FRAC_W;
	localparam int PROD_W = DATA_W + 1 + FRAC_W + 1;

	localparam logic [FRAC_W-1:0] Q_ONE = FRAC_W'(1) << FRAC_BITS;

	localparam logic [1:0] FUNC_WR_AXIS = 2'd0;
	localparam logic [1:0] FUNC_WR_GRID = 2'd1;
	localparam logic [1:0] FUNC_QUERY = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_CLAMP = 2'd1;
	localparam logic [1:0] ST_BAD_IDX = 2'd2;
	localparam logic [1:0] ST_ZERO_W = 2'd3;

	typedef logic signed [DATA_W-1:0] word_t;
	typedef word_t [NUM_BANKS-1:0] crn_t;

	typedef struct packed {
		logic [1:0] st;
		logic live;
	} ctl_t;

	typedef struct packed {
		ctl_t ctl;
		logic [NUM_AXES-1:0] neg;
		logic [NUM_AXES-1:0] over;
		crn_t crn;
	} div_pl_t;

endpackage

>>> sv/tgi_in_if.sv
interface tgi_in_if;
	logic valid;
	logic ready;
	logic [1:0] func;
	logic [1:0] axis_sel;
	logic [tgi_pkg::IDX_W-1:0] cell_i;
	logic [tgi_pkg::IDX_W-1:0] cell_j;
	logic [tgi_pkg::IDX_W-1:0] cell_k;
	logic signed [tgi_pkg::DATA_W-1:0] data_value;
	logic signed [tgi_pkg::DATA_W-1:0] point_a;
	logic signed [tgi_pkg::DATA_W-1:0] point_b;
	logic signed [tgi_pkg::DATA_W-1:0] point_c;

	modport source (
		output valid, func, axis_sel, cell_i, cell_j, cell_k,
		output data_value, point_a, point_b, point_c,
		input ready
	);
	modport sink (
		input valid, func, axis_sel, cell_i, cell_j, cell_k,
		input data_value, point_a, point_b, point_c,
		output ready
	);
endinterface

>>> sv/tgi_out_if.sv
interface tgi_out_if;
	logic valid;
	logic ready;
	logic signed [tgi_pkg::DATA_W-1:0] interp_value;
	logic [1:0] status;

	modport source (output valid, interp_value, status, input ready);
	modport sink (input valid, interp_value, status, output ready);
endinterface

>>> sv/tgi_div.sv
module tgi_div (
	input logic clk,
	input logic en,
	input logic [tgi_pkg::DATA_W-1:0] num,
	input logic [tgi_pkg::DATA_W-1:0] den,
	output logic [tgi_pkg::FRAC_W-1:0] quo
);
	localparam int N = tgi_pkg::DIV_STAGES;
	localparam int DW = tgi_pkg::DATA_W;
	localparam int RW = DW + 1;

	logic [RW-1:0] rem_sd [N];
	logic [DW-1:0] den_sd [N];
	logic [N-1:0] quo_sd [N];

	// first stage gives the integer bit, one fraction bit per later stage
	logic first_ge;
	assign first_ge = {1'b0, num} >= {1'b0, den};

	always_ff @(posedge clk) begin
		if (en) begin
			rem_sd[0] <= first_ge ? ({1'b0, num} - {1'b0, den}) : {1'b0, num};
			den_sd[0] <= den;
			quo_sd[0] <= {first_ge, (N-1)'(0)};
		end
	end

	genvar n;
	generate
		for (n = 1; n < N; n++) begin : g_step
			logic [RW:0] sh;
			logic ge;
			assign sh = {rem_sd[n-1], 1'b0};
			assign ge = sh >= {2'b00, den_sd[n-1]};
			always_ff @(posedge clk) begin
				if (en) begin
					rem_sd[n] <= ge ? RW'(sh - {2'b00, den_sd[n-1]}) : RW'(sh);
					den_sd[n] <= den_sd[n-1];
					quo_sd[n] <= quo_sd[n-1] | (N'(ge) << (N-1-n));
				end
			end
		end
	endgenerate

	assign quo = quo_sd[N-1];
endmodule

>>> sv/trilinear_grid_interpolator_unit.sv
// trilinear interpolation on a rectilinear 3-d grid, signed q16.16
// req channel: func selects an axis coordinate write (axis_sel, cell_i, data_value),
//   a grid value write (cell_i/j/k, data_value) or a query (cell_i/j/k as lower
//   cell corner, point_a/b/c as position)
// rsp channel: exactly one result per request, interp_value and status
//   (ok, clamped, bad index, zero-width cell); writes answer zero
// writes land in memory at the transfer edge, so a query right behind a write
//   already sees the new data
// the result is registered in s12, after s1..s3, the divider stages and s4..s11;
//   a new request is taken every cycle while rsp is not stalled, the three 17-stage
//   fraction dividers (one quotient bit per stage) set most of the pipeline depth
// the grid sits in eight banks by index parity and the axis tables in even/odd
//   banks, so all corners and both cell edges are read in the same cycle
// reset clears only the pipeline valid bits; the tables hold nothing defined
//   until written
// when rsp is stalled the whole pipeline holds and req.ready drops
module trilinear_grid_interpolator_unit (
	input logic clk,
	input logic arst_n,
	tgi_in_if.sink req,
	tgi_out_if.source rsp
);
	localparam int DW = tgi_pkg::DATA_W;
	localparam int HW = tgi_pkg::HALF_W;
	localparam int IW = tgi_pkg::IDX_W;
	localparam int NA = tgi_pkg::NUM_AXES;
	localparam int NB = tgi_pkg::NUM_BANKS;
	localparam int NS = tgi_pkg::DIV_STAGES;
	localparam int PW = tgi_pkg::PROD_W;
	localparam int FW = tgi_pkg::FRAC_W;
	localparam int GAW = tgi_pkg::GRID_AW;
	localparam logic signed [PW-1:0] RND = PW'(1) <<< (tgi_pkg::FRAC_BITS - 1);
	localparam logic signed [PW-1:0] SAT_HI = (PW'(1) <<< (tgi_pkg::SAT_BITS - 1)) - PW'(1);
	localparam logic signed [PW-1:0] SAT_LO = -SAT_HI - PW'(1);

	function automatic logic signed [PW-1:0] lerp_sum(
		input logic signed [DW-1:0] base,
		input logic signed [PW-1:0] prod
	);
		logic signed [PW-1:0] r;
		r = (prod + RND) >>> tgi_pkg::FRAC_BITS;
		return PW'(base) + r;
	endfunction

	logic adv, acc;
	assign adv = !rsp.valid || rsp.ready;
	assign req.ready = adv;
	assign acc = req.valid && adv;

	// request decode
	logic [IW-1:0] idx [NA];
	logic [IW:0] idx_nx [NA];
	logic [HW-1:0] ev_addr [NA];
	logic [HW-1:0] od_addr [NA];
	logic [NA-1:0] idx_bad, wr_bad;
	tgi_pkg::word_t pt_in [NA];
	logic [1:0] st_in;
	logic qry_in, wr_axis, wr_grid;
	logic [2:0] wr_bank;
	logic [GAW-1:0] wr_gaddr;
	logic [GAW-1:0] rd_gaddr [NB];

	always_comb begin
		idx[0] = req.cell_i;
		idx[1] = req.cell_j;
		idx[2] = req.cell_k;
		pt_in[0] = req.point_a;
		pt_in[1] = req.point_b;
		pt_in[2] = req.point_c;
		for (int a = 0; a < NA; a++) begin
			idx_nx[a] = {1'b0, idx[a]} + (IW+1)'(1);
			ev_addr[a] = idx_nx[a][HW:1];
			od_addr[a] = idx[a][HW:1];
			idx_bad[a] = 32'(idx_nx[a]) >= tgi_pkg::AXIS_POINTS;
			wr_bad[a] = 32'(idx[a]) >= tgi_pkg::AXIS_POINTS;
		end
		qry_in = 1'b0;
		unique case (req.func)
			tgi_pkg::FUNC_WR_AXIS: begin
				st_in = (32'(req.axis_sel) >= NA || wr_bad[0]) ?
					tgi_pkg::ST_BAD_IDX : tgi_pkg::ST_OK;
			end
			tgi_pkg::FUNC_WR_GRID: begin
				st_in = (|wr_bad) ? tgi_pkg::ST_BAD_IDX : tgi_pkg::ST_OK;
			end
			tgi_pkg::FUNC_QUERY: begin
				st_in = (|idx_bad) ? tgi_pkg::ST_BAD_IDX : tgi_pkg::ST_OK;
				qry_in = !(|idx_bad);
			end
			default: st_in = tgi_pkg::ST_BAD_IDX;
		endcase
		wr_axis = acc && req.func == tgi_pkg::FUNC_WR_AXIS && st_in == tgi_pkg::ST_OK;
		wr_grid = acc && req.func == tgi_pkg::FUNC_WR_GRID && st_in == tgi_pkg::ST_OK;
		wr_bank = {idx[0][0], idx[1][0], idx[2][0]};
		wr_gaddr = {idx[0][HW:1], idx[1][HW:1], idx[2][HW:1]};
		// each bank holds one parity per axis: pick the edge of that parity
		for (int b = 0; b < NB; b++) begin
			rd_gaddr[b] = {((b >> 2) & 1) != 0 ? od_addr[0] : ev_addr[0],
				((b >> 1) & 1) != 0 ? od_addr[1] : ev_addr[1],
				(b & 1) != 0 ? od_addr[2] : ev_addr[2]};
		end
	end

	// axis tables and grid banks
	tgi_pkg::word_t crd_ev_mem [NA][tgi_pkg::BANK_DEPTH];
	tgi_pkg::word_t crd_od_mem [NA][tgi_pkg::BANK_DEPTH];
	tgi_pkg::word_t grid_mem [NB][tgi_pkg::GRID_BANK_DEPTH];
	tgi_pkg::word_t crd_ev_s1 [NA];
	tgi_pkg::word_t crd_od_s1 [NA];
	tgi_pkg::word_t grid_s1 [NB];

	always_ff @(posedge clk) begin
		for (int a = 0; a < NA; a++) begin
			if (wr_axis && req.axis_sel == 2'(a) && !idx[0][0])
				crd_ev_mem[a][idx[0][HW:1]] <= req.data_value;
			if (wr_axis && req.axis_sel == 2'(a) && idx[0][0])
				crd_od_mem[a][idx[0][HW:1]] <= req.data_value;
			if (adv) begin
				crd_ev_s1[a] <= crd_ev_mem[a][ev_addr[a]];
				crd_od_s1[a] <= crd_od_mem[a][od_addr[a]];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int b = 0; b < NB; b++) begin
			if (wr_grid && wr_bank == 3'(b))
				grid_mem[b][wr_gaddr] <= req.data_value;
			if (adv)
				grid_s1[b] <= grid_mem[b][rd_gaddr[b]];
		end
	end

	// pipeline registers
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;
	logic [NS-1:0] dv_v_sd;

	logic [1:0] st_s1, st_s2;
	logic qry_s1, qry_s2;
	logic [2:0] par_s1;
	tgi_pkg::word_t pt_s1 [NA];

	logic signed [DW:0] num_s2 [NA];
	logic signed [DW:0] w_s2 [NA];
	tgi_pkg::crn_t crn_s2;

	logic [DW-1:0] an_s3 [NA];
	logic [DW-1:0] aw_s3 [NA];
	tgi_pkg::div_pl_t pl_s3;
	tgi_pkg::div_pl_t dly_sd [NS];
	logic [FW-1:0] quo [NA];

	logic [FW-1:0] m_s4 [NA];
	logic signed [DW:0] ld_s4 [4];
	tgi_pkg::word_t lb_s4 [4];
	tgi_pkg::ctl_t ctl_s4, ctl_s5, ctl_s6, ctl_s7, ctl_s8, ctl_s9, ctl_s10, ctl_s11;
	logic signed [PW-1:0] lp_s5 [4];
	tgi_pkg::word_t lb_s5 [4];
	logic [FW-1:0] m1_s5, m0_s5, m1_s6, m0_s6, m1_s7, m0_s7;
	logic [FW-1:0] m0_s8, m0_s9, m0_s10;
	tgi_pkg::word_t lc_s6 [4];
	logic signed [DW:0] ld_s7 [2];
	tgi_pkg::word_t lb_s7 [2];
	logic signed [PW-1:0] lp_s8 [2];
	tgi_pkg::word_t lb_s8 [2];
	tgi_pkg::word_t ldd_s9 [2];
	logic signed [DW:0] ld_s10;
	tgi_pkg::word_t lb_s10;
	logic signed [PW-1:0] lp_s11;
	tgi_pkg::word_t lb_s11;
	tgi_pkg::word_t val_s12;
	logic [1:0] st_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			dv_v_sd <= '0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			dv_v_sd <= {dv_v_sd[NS-2:0], v_s3};
			v_s4 <= dv_v_sd[NS-1];
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
		end
	end

	// stage 3 flags: exact ratio test and zero-width check
	logic signed [DW:0] an_c [NA];
	logic signed [DW:0] aw_c [NA];
	logic [NA-1:0] neg_c, over_c, zero_c;
	tgi_pkg::ctl_t ctl_c;
	always_comb begin
		for (int a = 0; a < NA; a++) begin
			an_c[a] = num_s2[a] < 0 ? -num_s2[a] : num_s2[a];
			aw_c[a] = w_s2[a] < 0 ? -w_s2[a] : w_s2[a];
			neg_c[a] = num_s2[a] != 0 && ((num_s2[a] < 0) != (w_s2[a] < 0));
			over_c[a] = an_c[a] > aw_c[a];
			zero_c[a] = w_s2[a] == 0;
		end
		ctl_c.live = qry_s2 && !(|zero_c);
		priority if (st_s2 != tgi_pkg::ST_OK) ctl_c.st = st_s2;
		else if (qry_s2 && (|zero_c)) ctl_c.st = tgi_pkg::ST_ZERO_W;
		else if (qry_s2 && ((|neg_c) || (|over_c))) ctl_c.st = tgi_pkg::ST_CLAMP;
		else ctl_c.st = tgi_pkg::ST_OK;
	end

	genvar g;
	generate
		for (g = 0; g < NA; g++) begin : g_div
			tgi_div u_div (
				.clk(clk),
				.en(adv),
				.num(an_s3[g]),
				.den(aw_s3[g]),
				.quo(quo[g])
			);
		end
	endgenerate

	tgi_pkg::div_pl_t pl_out;
	assign pl_out = dly_sd[NS-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			// s1: memory reads and request fields
			st_s1 <= st_in;
			qry_s1 <= qry_in;
			par_s1 <= {idx[0][0], idx[1][0], idx[2][0]};
			for (int a = 0; a < NA; a++)
				pt_s1[a] <= pt_in[a];

			// s2: cell edges, offsets and corner values
			st_s2 <= st_s1;
			qry_s2 <= qry_s1;
			for (int a = 0; a < NA; a++) begin
				num_s2[a] <= {pt_s1[a][DW-1], pt_s1[a]} -
					(par_s1[NA-1-a] ? {crd_od_s1[a][DW-1], crd_od_s1[a]} :
						{crd_ev_s1[a][DW-1], crd_ev_s1[a]});
				w_s2[a] <= (par_s1[NA-1-a] ? {crd_ev_s1[a][DW-1], crd_ev_s1[a]} :
						{crd_od_s1[a][DW-1], crd_od_s1[a]}) -
					(par_s1[NA-1-a] ? {crd_od_s1[a][DW-1], crd_od_s1[a]} :
						{crd_ev_s1[a][DW-1], crd_ev_s1[a]});
			end
			for (int d = 0; d < NB; d++)
				crn_s2[d] <= grid_s1[3'(d) ^ par_s1];

			// s3: magnitudes for the dividers
			for (int a = 0; a < NA; a++) begin
				an_s3[a] <= an_c[a][DW-1:0];
				aw_s3[a] <= aw_c[a][DW-1:0];
			end
			pl_s3.ctl <= ctl_c;
			pl_s3.neg <= neg_c;
			pl_s3.over <= over_c;
			pl_s3.crn <= crn_s2;

			// payload beside the divider stages
			dly_sd[0] <= pl_s3;
			for (int n = 1; n < NS; n++)
				dly_sd[n] <= dly_sd[n-1];

			// s4: clamped weights and first differences along axis 2
			for (int a = 0; a < NA; a++)
				m_s4[a] <= pl_out.neg[a] ? FW'(0) :
					(pl_out.over[a] ? tgi_pkg::Q_ONE : quo[a]);
			for (int p = 0; p < 4; p++) begin
				ld_s4[p] <= {pl_out.crn[2*p+1][DW-1], pl_out.crn[2*p+1]} -
					{pl_out.crn[2*p][DW-1], pl_out.crn[2*p]};
				lb_s4[p] <= pl_out.crn[2*p];
			end
			ctl_s4 <= pl_out.ctl;

			// s5..s6: axis 2 blend
			for (int p = 0; p < 4; p++) begin
				lp_s5[p] <= ld_s4[p] * $signed({1'b0, m_s4[2]});
				lb_s5[p] <= lb_s4[p];
				lc_s6[p] <= DW'(lerp_sum(lb_s5[p], lp_s5[p]));
			end
			m1_s5 <= m_s4[1];
			m0_s5 <= m_s4[0];
			m1_s6 <= m1_s5;
			m0_s6 <= m0_s5;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;

			// s7..s9: axis 1 blend
			for (int q = 0; q < 2; q++) begin
				ld_s7[q] <= {lc_s6[2*q+1][DW-1], lc_s6[2*q+1]} -
					{lc_s6[2*q][DW-1], lc_s6[2*q]};
				lb_s7[q] <= lc_s6[2*q];
				lp_s8[q] <= ld_s7[q] * $signed({1'b0, m1_s7});
				lb_s8[q] <= lb_s7[q];
				ldd_s9[q] <= DW'(lerp_sum(lb_s8[q], lp_s8[q]));
			end
			m1_s7 <= m1_s6;
			m0_s7 <= m0_s6;
			m0_s8 <= m0_s7;
			m0_s9 <= m0_s8;
			ctl_s7 <= ctl_s6;
			ctl_s8 <= ctl_s7;
			ctl_s9 <= ctl_s8;

			// s10..s12: axis 0 blend, saturation and output register
			ld_s10 <= {ldd_s9[1][DW-1], ldd_s9[1]} - {ldd_s9[0][DW-1], ldd_s9[0]};
			lb_s10 <= ldd_s9[0];
			m0_s10 <= m0_s9;
			ctl_s10 <= ctl_s9;
			lp_s11 <= ld_s10 * $signed({1'b0, m0_s10});
			lb_s11 <= lb_s10;
			ctl_s11 <= ctl_s10;
			if (!ctl_s11.live)
				val_s12 <= '0;
			else if (lerp_sum(lb_s11, lp_s11) > SAT_HI)
				val_s12 <= SAT_HI[DW-1:0];
			else if (lerp_sum(lb_s11, lp_s11) < SAT_LO)
				val_s12 <= SAT_LO[DW-1:0];
			else
				val_s12 <= DW'(lerp_sum(lb_s11, lp_s11));
			st_s12 <= ctl_s11.st;
		end
	end

	assign rsp.valid = v_s12;
	assign rsp.interp_value = val_s12;
	assign rsp.status = st_s12;
endmodule

>>> tb/tgi_checker.sv
`timescale 1ns / 1ps

module tgi_checker (
	input logic clk,
	input logic arst_n,
	tgi_in_if req,
	tgi_out_if rsp,
	output int fails,
	output int pending
);

	localparam longint ONE = 64'sd65536;
	localparam int AXIS_POINTS = tgi_pkg::AXIS_POINTS;
	localparam int NUM_AXES = tgi_pkg::NUM_AXES;

	typedef struct {
		tgi_pkg::word_t value;
		logic [1:0] st;
	} answer_t;

	answer_t answers[$];
	tgi_pkg::word_t axis_tab[NUM_AXES*AXIS_POINTS];
	tgi_pkg::word_t grid_tab[AXIS_POINTS*AXIS_POINTS*AXIS_POINTS];

	initial begin
		fails = 0;
		pending = 0;
	end

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		fails++;
	endtask

	// position inside the cell as a q16 weight, clamped to [0,1]
	function automatic longint cell_weight(input longint p, input longint lo, input longint hi,
			inout bit clamped);
		longint num;
		longint w;
		num = p - lo;
		w = hi - lo;
		if (num != 0 && ((num < 0) != (w < 0))) begin
			clamped = 1;
			return 0;
		end
		if ((num < 0 ? -num : num) > (w < 0 ? -w : w)) begin
			clamped = 1;
			return ONE;
		end
		return (num * ONE) / w;
	endfunction

	function automatic longint blend(input longint a, input longint b, input longint m);
		return (a * (ONE - m) + b * m + 32768) >>> 16;
	endfunction

	function automatic longint corner(input int i, input int j, input int k);
		return grid_tab[(i * AXIS_POINTS + j) * AXIS_POINTS + k];
	endfunction

	function automatic answer_t interpolate(input logic [1:0] func, input logic [1:0] sel,
			input int i, input int j, input int k, input tgi_pkg::word_t d,
			input tgi_pkg::word_t pa, input tgi_pkg::word_t pb, input tgi_pkg::word_t pc);
		answer_t r;
		bit clamped;
		longint m0, m1, m2, c00, c01, c10, c11, d0, d1, v;
		r.value = '0;
		r.st = tgi_pkg::ST_OK;
		clamped = 0;
		case (func)
			tgi_pkg::FUNC_WR_AXIS: begin
				if (sel > 2) r.st = tgi_pkg::ST_BAD_IDX;
				else axis_tab[sel * AXIS_POINTS + i] = d;
			end
			tgi_pkg::FUNC_WR_GRID: grid_tab[(i * AXIS_POINTS + j) * AXIS_POINTS + k] = d;
			tgi_pkg::FUNC_QUERY: begin
				if (i + 1 >= AXIS_POINTS || j + 1 >= AXIS_POINTS || k + 1 >= AXIS_POINTS) begin
					r.st = tgi_pkg::ST_BAD_IDX;
				end else if (axis_tab[i] == axis_tab[i+1]
						|| axis_tab[AXIS_POINTS+j] == axis_tab[AXIS_POINTS+j+1]
						|| axis_tab[2*AXIS_POINTS+k] == axis_tab[2*AXIS_POINTS+k+1]) begin
					r.st = tgi_pkg::ST_ZERO_W;
				end else begin
					m0 = cell_weight(pa, axis_tab[i], axis_tab[i+1], clamped);
					m1 = cell_weight(pb, axis_tab[AXIS_POINTS+j], axis_tab[AXIS_POINTS+j+1],
						clamped);
					m2 = cell_weight(pc, axis_tab[2*AXIS_POINTS+k],
						axis_tab[2*AXIS_POINTS+k+1], clamped);
					c00 = blend(corner(i, j, k), corner(i, j, k+1), m2);
					c01 = blend(corner(i, j+1, k), corner(i, j+1, k+1), m2);
					c10 = blend(corner(i+1, j, k), corner(i+1, j, k+1), m2);
					c11 = blend(corner(i+1, j+1, k), corner(i+1, j+1, k+1), m2);
					d0 = blend(c00, c01, m1);
					d1 = blend(c10, c11, m1);
					v = blend(d0, d1, m0);
					if (v > 64'sd2147483647) v = 64'sd2147483647;
					if (v < -64'sd2147483648) v = -64'sd2147483648;
					r.value = tgi_pkg::word_t'(v);
					r.st = clamped ? tgi_pkg::ST_CLAMP : tgi_pkg::ST_OK;
				end
			end
			default: r.st = tgi_pkg::ST_BAD_IDX;
		endcase
		return r;
	endfunction

	always @(posedge clk) begin
		answer_t want;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				if (answers.size() == 0) begin
					report("unexpected result", rsp.interp_value, 0);
				end else begin
					want = answers.pop_front();
					if (rsp.interp_value !== want.value)
						report("interp_value", rsp.interp_value, want.value);
					if (rsp.status !== want.st)
						report("status", rsp.status, want.st);
				end
			end
			if (req.valid && req.ready)
				answers.insert(answers.size(), interpolate(req.func, req.axis_sel,
					req.cell_i, req.cell_j, req.cell_k, req.data_value, req.point_a,
					req.point_b, req.point_c));
			pending = answers.size();
		end
	end

endmodule

>>> tb/tb_trilinear_grid_interpolator_unit.sv
`timescale 1ns / 1ps

module tb_trilinear_grid_interpolator_unit;

	localparam int AXIS_POINTS = tgi_pkg::AXIS_POINTS;
	localparam int NUM_AXES = tgi_pkg::NUM_AXES;
	localparam int IW = tgi_pkg::IDX_W;
	localparam logic [1:0] FUNC_NONE = 2'd3;
	localparam logic [1:0] AXIS_NONE = 2'd3;
	localparam int LATENCY = 28;

	logic clk = 0;
	logic arst_n = 0;
	int fails;
	int pending;
	bit steady = 0;
	bit squeeze_go = 0;
	bit squeeze_done = 0;

	longint axis_mirror[NUM_AXES*AXIS_POINTS];
	bit grid_set[AXIS_POINTS*AXIS_POINTS*AXIS_POINTS];

	tgi_in_if req_ch();
	tgi_out_if rsp_ch();

	trilinear_grid_interpolator_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	tgi_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.fails(fails),
		.pending(pending)
	);

	always #5 clk = ~clk;

	initial begin
		#5ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	// one transfer on the request channel, idle gaps first
	task automatic send_request(input logic [1:0] func, input logic [1:0] sel,
			input int i, input int j, input int k, input tgi_pkg::word_t d,
			input tgi_pkg::word_t pa, input tgi_pkg::word_t pb, input tgi_pkg::word_t pc);
		while (!steady && $urandom_range(0, 99) < 35) begin
			req_ch.valid = 0;
			@(negedge clk);
		end
		req_ch.func = func;
		req_ch.axis_sel = sel;
		req_ch.cell_i = IW'(i);
		req_ch.cell_j = IW'(j);
		req_ch.cell_k = IW'(k);
		req_ch.data_value = d;
		req_ch.point_a = pa;
		req_ch.point_b = pb;
		req_ch.point_c = pc;
		req_ch.valid = 1;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	function automatic tgi_pkg::word_t noise();
		return tgi_pkg::word_t'($urandom);
	endfunction

	task automatic put_axis(input int a, input int n, input tgi_pkg::word_t v);
		axis_mirror[a*AXIS_POINTS+n] = v;
		send_request(tgi_pkg::FUNC_WR_AXIS, 2'(a), n, $urandom_range(0, 15),
			$urandom_range(0, 15), v, noise(), noise(), noise());
	endtask

	task automatic put_grid(input int i, input int j, input int k, input tgi_pkg::word_t v);
		grid_set[(i*AXIS_POINTS+j)*AXIS_POINTS+k] = 1;
		send_request(tgi_pkg::FUNC_WR_GRID, 2'($urandom_range(0, 3)), i, j, k, v, noise(),
			noise(), noise());
	endtask

	function automatic tgi_pkg::word_t grid_word();
		case ($urandom_range(0, 9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2, 3: return noise();
			default: return tgi_pkg::word_t'($signed($urandom_range(0, 32'h01ffffff))
				- 32'sh01000000);
		endcase
	endfunction

	// only corners that were written may be read by a query
	task automatic fill_cell(input int i, input int j, input int k);
		for (int n = 0; n < 8; n++)
			if (!grid_set[((i+n[2])*AXIS_POINTS+j+n[1])*AXIS_POINTS+k+n[0]])
				put_grid(i+n[2], j+n[1], k+n[0], grid_word());
	endtask

	function automatic tgi_pkg::word_t pick_point(input int a, input int n);
		longint lo;
		longint hi;
		lo = axis_mirror[a*AXIS_POINTS+n];
		hi = axis_mirror[a*AXIS_POINTS+n+1];
		case ($urandom_range(0, 9))
			7: return tgi_pkg::word_t'(lo);
			8: return noise();
			9: return tgi_pkg::word_t'(hi);
			default: return tgi_pkg::word_t'(lo
				+ ((hi - lo) * longint'($urandom_range(0, 65536))) / 65536);
		endcase
	endfunction

	task automatic query(input int i, input int j, input int k);
		if (i < 15 && j < 15 && k < 15) fill_cell(i, j, k);
		send_request(tgi_pkg::FUNC_QUERY, 2'($urandom_range(0, 3)), i, j, k, noise(),
			i < 15 ? pick_point(0, i) : noise(), j < 15 ? pick_point(1, j) : noise(),
			k < 15 ? pick_point(2, k) : noise());
	endtask

	// queries stay near the table ends so few corners need filling
	function automatic int pick_cell();
		return $urandom_range(0, 1) != 0 ? int'($urandom_range(0, 1))
			: int'($urandom_range(13, 14));
	endfunction

	task automatic random_query();
		if ($urandom_range(0, 19) == 0)
			query($urandom_range(0, 15), $urandom_range(0, 15), 15);
		else
			query(pick_cell(), pick_cell(), pick_cell());
	endtask

	task automatic random_axis_write();
		int a;
		int n;
		a = $urandom_range(0, 2);
		n = $urandom_range(0, 15);
		case ($urandom_range(0, 4))
			0: put_axis(a, n, noise());
			1: put_axis(a, n,
				tgi_pkg::word_t'(axis_mirror[a*AXIS_POINTS+(n == 15 ? 14 : n+1)]));
			default: put_axis(a, n, tgi_pkg::word_t'(axis_mirror[a*AXIS_POINTS+n]
				+ $signed($urandom_range(0, 32'h1ffff)) - 32'sh10000));
		endcase
	endtask

	// receiver: random stalls, one long hold-off while the sender keeps going
	initial begin
		rsp_ch.ready = 0;
		forever begin
			@(negedge clk);
			if (squeeze_go && !squeeze_done) begin
				rsp_ch.ready = 0;
				for (int c = 0; c < 300; c++) @(negedge clk);
				squeeze_done = 1;
			end
			rsp_ch.ready = steady || $urandom_range(0, 99) >= 35;
		end
	end

	initial begin
		int wait_cycles;
		req_ch.valid = 0;
		req_ch.func = tgi_pkg::FUNC_WR_AXIS;
		req_ch.axis_sel = 0;
		req_ch.cell_i = 0;
		req_ch.cell_j = 0;
		req_ch.cell_k = 0;
		req_ch.data_value = 0;
		req_ch.point_a = 0;
		req_ch.point_b = 0;
		req_ch.point_c = 0;
		repeat (9) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// ascending tables; axis 2 descends
		for (int a = 0; a < NUM_AXES; a++)
			for (int n = 0; n < AXIS_POINTS; n++)
				put_axis(a, n, tgi_pkg::word_t'((a == 2 ? -n : n)
					* $signed($urandom_range(1, 3)) * 32'sh10000
					+ (a == 2 ? 32'sh100000 : -32'sh100000)));

		// directed corners
		fill_cell(0, 0, 0);
		put_grid(0, 0, 0, 32'sh7fffffff);
		put_grid(1, 1, 1, 32'sh80000000);
		send_request(tgi_pkg::FUNC_QUERY, 2'd0, 0, 0, 0, 0, 32'sh80000000, 32'sh7fffffff,
			32'sh80000000);
		send_request(tgi_pkg::FUNC_QUERY, 2'd0, 0, 0, 0, 0, 32'sh7fffffff, 32'sh80000000,
			32'sh7fffffff);
		query(0, 0, 0);
		query(14, 14, 14);
		query(15, 0, 0);
		query(0, 15, 0);
		query(0, 0, 15);
		send_request(tgi_pkg::FUNC_WR_AXIS, AXIS_NONE, 3, 3, 3, 32'sh7fffffff, 0, 0, 0);
		send_request(FUNC_NONE, 2'd0, 15, 15, 15, 32'sh80000000, 0, 0, 0);
		put_axis(1, 5, tgi_pkg::word_t'(axis_mirror[AXIS_POINTS+6]));
		query(2, 5, 2);
		put_axis(1, 5, tgi_pkg::word_t'(axis_mirror[AXIS_POINTS+6] - 32'sh8000));
		query(2, 5, 2);
		put_axis(0, 15, 32'sh7fffffff);
		put_axis(0, 14, 32'sh80000000);
		query(14, 3, 3);
		put_grid(15, 15, 15, grid_word());

		for (int n = 0; n < 550; n++) begin
			steady = n >= 350 && n < 450;
			if (n == 150) squeeze_go = 1;
			case ($urandom_range(0, 19))
				0, 1, 2: put_grid($urandom_range(0, 15), $urandom_range(0, 15),
					$urandom_range(0, 15), grid_word());
				3, 4: random_axis_write();
				5: send_request($urandom_range(0, 1) ? FUNC_NONE : tgi_pkg::FUNC_WR_AXIS,
					AXIS_NONE, $urandom_range(0, 15), $urandom_range(0, 15),
					$urandom_range(0, 15), noise(), noise(), noise(), noise());
				default: random_query();
			endcase
		end
		steady = 0;
		req_ch.valid = 0;

		wait_cycles = 0;
		while (pending != 0 && wait_cycles < 20000) begin
			@(negedge clk);
			wait_cycles++;
		end
		repeat (LATENCY + 10) @(negedge clk);
		if (fails == 0 && pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
